>>> rtl/age_ordered_request_queue_macros.svh
// ----------------------------------------------------------------------------
// age ordered request queue assertion macros
// clocked assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef AGE_ORDERED_REQUEST_QUEUE_MACROS_SVH
`define AGE_ORDERED_REQUEST_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AORQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define AORQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AORQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AORQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/aorq_pkg.sv
// ----------------------------------------------------------------------------
// aorq_pkg
// shared widths, codes and structs of the age ordered request queue
// ----------------------------------------------------------------------------
package aorq_pkg;

  // sizes
  localparam int Depth    = 16;
  localparam int IdxW     = 4;
  localparam int CntW     = 5;
  localparam int PayW     = 32;
  localparam int AgeW     = 64;
  localparam int ActW     = 3;
  localparam int StatW    = 2;
  localparam int PosW     = 5;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [CntW-1:0] MaxSizeReset = 5'd16;

  // register index taken from paddr bit 2
  localparam logic RegMaxSize = 1'b0;

  // request action codes
  typedef enum logic [ActW-1:0] {
    ActAppend = 3'd0,
    ActInsert = 3'd1,
    ActPeek   = 3'd2,
    ActRemove = 3'd3,
    ActAgeAll = 3'd4,
    ActSetAge = 3'd5
  } action_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    StDone     = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2
  } status_e;

  // qualified operation broadcast to the cells
  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpAppend = 3'd1,
    OpInsert = 3'd2,
    OpRemove = 3'd3,
    OpAge    = 3'd4,
    OpSetAge = 3'd5
  } op_e;

  typedef struct packed {
    logic [PayW-1:0] payload;
    logic [AgeW-1:0] age;
  } entry_t;

  typedef struct packed {
    op_e             op;
    logic [PayW-1:0] payload;
    logic [AgeW-1:0] age_value;
    logic [AgeW-1:0] age_step;
  } cell_cmd_t;

  typedef struct packed {
    logic occupied;
    logic at_end;
    logic at_pos;
    logic past_pos;
  } cell_ctrl_t;

  typedef struct packed {
    status_e         status;
    logic [PayW-1:0] payload_out;
    logic [AgeW-1:0] age_out;
    logic [CntW-1:0] count;
    logic            empty_flag;
    logic            full_flag;
  } result_t;

endpackage

>>> rtl/aorq_req_if.sv
// ----------------------------------------------------------------------------
// aorq_req_if
// request channel of the age ordered request queue
// ----------------------------------------------------------------------------
interface aorq_req_if
  import aorq_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;
  logic [PayW-1:0] payload;
  logic [AgeW-1:0] age_value;
  logic [PosW-1:0] position;
  logic [AgeW-1:0] age_step;

  modport source (
    output valid, action, payload, age_value, position, age_step,
    input  ready
  );

  modport sink (
    input  valid, action, payload, age_value, position, age_step,
    output ready
  );
endinterface

>>> rtl/aorq_rsp_if.sv
// ----------------------------------------------------------------------------
// aorq_rsp_if
// result channel of the age ordered request queue
// ----------------------------------------------------------------------------
interface aorq_rsp_if
  import aorq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [PayW-1:0]  payload_out;
  logic [AgeW-1:0]  age_out;
  logic [CntW-1:0]  count;
  logic             empty_flag;
  logic             full_flag;

  modport source (
    output valid, status, payload_out, age_out, count, empty_flag, full_flag,
    input  ready
  );

  modport sink (
    input  valid, status, payload_out, age_out, count, empty_flag, full_flag,
    output ready
  );
endinterface

>>> rtl/aorq_cell.sv
// ----------------------------------------------------------------------------
// aorq_cell
// one queue slot: holds an entry and shifts with its neighbors
// ----------------------------------------------------------------------------
module aorq_cell
  import aorq_pkg::*;
(
  input  logic       clk_i,
  input  cell_cmd_t  cmd_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  input  logic       ins_i,
  output logic       ins_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;
  logic   older;

  // insert point found here or in a cell to the left
  assign older = ctrl_i.occupied && (cmd_i.age_value < entry_q.age);
  assign ins_o = ins_i | older;

  // next slot content
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OpAppend: begin
        if (ctrl_i.at_end) begin
          entry_d.payload = cmd_i.payload;
          entry_d.age     = '0;
        end
      end
      OpInsert: begin
        if (ins_i) begin
          entry_d = left_i;
        end else if (older || ctrl_i.at_end) begin
          entry_d.payload = cmd_i.payload;
          entry_d.age     = cmd_i.age_value;
        end
      end
      OpRemove: begin
        if (ctrl_i.past_pos) begin
          entry_d = right_i;
        end
      end
      OpAge: begin
        entry_d.age = (entry_q.age > cmd_i.age_step) ? entry_q.age - cmd_i.age_step : '0;
      end
      OpSetAge: begin
        if (ctrl_i.at_pos) begin
          entry_d.age = cmd_i.age_value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/age_ordered_request_queue.sv
// ----------------------------------------------------------------------------
// age_ordered_request_queue
// bounded queue of request handles kept in a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   req_i carries one action per beat: append, sorted insert, peek, remove,
//   age all or set age, with payload, age, position and age step fields.
//   rsp_o returns exactly one result beat per request beat, in order, with
//   status, peeked or removed payload, age, count and empty / full flags.
//   the result is registered and shows in the cycle after the request beat
//   is taken. throughput: one request per cycle while rsp_o is not stalled;
//   every cell compares and shifts in parallel in the cycle of acceptance.
//   when rsp_o is stalled the result register holds and req_i.ready drops,
//   so no request is taken until that result beat is taken.
//   reset empties the queue (count 0) and sets max_size to 16; slot contents
//   are not cleared and are never read before being written.
//   the apb port holds max_size at address 0; the user must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
`include "age_ordered_request_queue_macros.svh"

module age_ordered_request_queue
  import aorq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  aorq_req_if.sink            req_i,
  aorq_rsp_if.source          rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CntW-1:0] max_size_q;
  logic [CntW-1:0] count_q, count_d, count_nx;
  logic [CntW-1:0] cap;
  logic [CntW-1:0] pos_m1;
  logic [IdxW-1:0] pos_idx;
  logic            out_valid_q, out_valid_d;
  logic            acc, full_now, pos_ok;
  logic            grow_op, shrink_op;
  op_e             op_sel;
  cell_cmd_t       cmd;
  cell_ctrl_t      ctrl [Depth];
  entry_t          entries [Depth];
  logic            ins_chain [Depth+1];
  entry_t          sel_entry;
  result_t         res_d, res_q;

  // apb register access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxSize) ? ApbDataW'(max_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxSizeReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegMaxSize)) begin
      max_size_q <= pwdata[CntW-1:0];
    end
  end

  // handshake
  assign acc         = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || rsp_o.ready;

  // capacity and position checks
  assign cap      = (max_size_q < CntW'(Depth)) ? max_size_q : CntW'(Depth);
  assign full_now = count_q >= cap;
  assign pos_ok   = (req_i.position != '0) && (req_i.position <= count_q);
  assign pos_m1   = req_i.position - 1'b1;
  assign pos_idx  = pos_m1[IdxW-1:0];
  assign sel_entry = entries[pos_idx];

  // action decode and result
  always_comb begin
    op_sel            = OpNone;
    count_nx          = count_q;
    res_d.status      = StDone;
    res_d.payload_out = '0;
    res_d.age_out     = '0;
    case (req_i.action)
      ActAppend, ActInsert: begin
        if (full_now) begin
          res_d.status = StFull;
        end else begin
          op_sel   = (req_i.action == ActAppend) ? OpAppend : OpInsert;
          count_nx = count_q + 1'b1;
        end
      end
      ActPeek: begin
        if (pos_ok) begin
          res_d.payload_out = sel_entry.payload;
          res_d.age_out     = sel_entry.age;
        end else begin
          res_d.status  = StNotFound;
          res_d.age_out = '1;
        end
      end
      ActRemove: begin
        if (pos_ok) begin
          res_d.payload_out = sel_entry.payload;
          op_sel            = OpRemove;
          count_nx          = count_q - 1'b1;
        end else begin
          res_d.status  = StNotFound;
          res_d.age_out = '1;
        end
      end
      ActAgeAll: begin
        op_sel = OpAge;
      end
      ActSetAge: begin
        if (pos_ok) begin
          op_sel = OpSetAge;
        end else begin
          res_d.status  = StNotFound;
          res_d.age_out = '1;
        end
      end
      default: begin
        op_sel = OpNone;
      end
    endcase
    res_d.count      = count_nx;
    res_d.empty_flag = (count_nx == '0);
    res_d.full_flag  = (count_nx >= cap);
  end

  // command broadcast to the cells
  assign cmd.op        = acc ? op_sel : OpNone;
  assign cmd.payload   = req_i.payload;
  assign cmd.age_value = req_i.age_value;
  assign cmd.age_step  = req_i.age_step;

  assign count_d     = acc ? count_nx : count_q;
  assign out_valid_d = acc ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = res_q.status;
  assign rsp_o.payload_out = res_q.payload_out;
  assign rsp_o.age_out     = res_q.age_out;
  assign rsp_o.count       = res_q.count;
  assign rsp_o.empty_flag  = res_q.empty_flag;
  assign rsp_o.full_flag   = res_q.full_flag;

  // row of cells
  assign ins_chain[0] = 1'b0;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    entry_t left, right;

    assign ctrl[k].occupied = count_q > CntW'(k);
    assign ctrl[k].at_end   = count_q == CntW'(k);
    assign ctrl[k].at_pos   = pos_m1 == CntW'(k);
    assign ctrl[k].past_pos = CntW'(k) >= pos_m1;

    if (k == 0) begin : g_first
      assign left = entries[k];
    end else begin : g_mid_l
      assign left = entries[k-1];
    end

    if (k == Depth - 1) begin : g_last
      assign right = entries[k];
    end else begin : g_mid_r
      assign right = entries[k+1];
    end

    aorq_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .ctrl_i  (ctrl[k]),
      .left_i  (left),
      .right_i (right),
      .ins_i   (ins_chain[k]),
      .ins_o   (ins_chain[k+1]),
      .entry_o (entries[k])
    );
  end

  // checks
  assign grow_op   = (cmd.op == OpAppend) || (cmd.op == OpInsert);
  assign shrink_op = (cmd.op == OpRemove);

  `AORQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth))
  `AORQ_ASSERT_NXT(a_insert_grows, clk_i, rst_ni, grow_op, count_q == $past(count_q) + 1'b1)
  `AORQ_ASSERT_NXT(a_remove_shrinks, clk_i, rst_ni, shrink_op, count_q == $past(count_q) - 1'b1)
  `AORQ_ASSERT_IMP(a_stall_blocks, clk_i, rst_ni, out_valid_q && !rsp_o.ready, !req_i.ready)
  `AORQ_ASSERT_IMP(a_reject_no_op, clk_i, rst_ni, acc && res_d.status == StFull, cmd.op == OpNone)

endmodule

>>> test/age_ordered_request_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_ordered_request_queue_tb
// drives request beats and max_size writes into the queue, predicts every
// result beat with a shadow queue and compares each result field by field
// ----------------------------------------------------------------------------
module age_ordered_request_queue_tb
  import aorq_pkg::*;
();

  // action codes the block leaves unused
  localparam logic [ActW-1:0]     ActSpare6   = 3'd6;
  localparam logic [ActW-1:0]     ActSpare7   = 3'd7;
  localparam logic [ApbAddrW-1:0] AddrMaxSize = 3'd0;
  localparam int                  StuckLimit  = 1000;
  localparam int                  NumPhases   = 10;
  localparam int                  PhaseItems  = 82;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [PayW-1:0] payload;
    logic [AgeW-1:0] age_value;
    logic [PosW-1:0] position;
    logic [AgeW-1:0] age_step;
  } request_t;

  // shadow queue and the results it predicts
  class request_queue_checker;
    logic [PayW-1:0] payloads [Depth];
    logic [AgeW-1:0] ages [Depth];
    int unsigned     n_entries;
    logic [CntW-1:0] max_size;
    result_t         pending_results [$];
    int unsigned     errors;

    function new();
      n_entries = 0;
      max_size  = MaxSizeReset;
      errors    = 0;
    endfunction

    function void set_max_size(logic [CntW-1:0] value);
      max_size = value;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // apply one accepted request beat to the shadow queue
    function void note_request(request_t beat);
      result_t         want;
      int unsigned     cap;
      int unsigned     slot;
      int unsigned     k;
      logic [AgeW-1:0] age;
      bit              placed;
      bit              pos_ok;
      cap    = (max_size < Depth) ? max_size : Depth;
      pos_ok = (beat.position >= 1) && (beat.position <= n_entries);
      want   = '0;
      want.status = StDone;
      case (beat.action)
        ActAppend, ActInsert: begin
          if (n_entries >= cap) begin
            want.status = StFull;
          end else begin
            slot   = n_entries;
            age    = '0;
            placed = 1'b0;
            // sorted insert goes in front of the first strictly older entry
            if (beat.action == ActInsert) begin
              age = beat.age_value;
              for (k = 0; k < n_entries; k++) begin
                if (!placed && age < ages[k]) begin
                  slot   = k;
                  placed = 1'b1;
                end
              end
            end
            for (k = n_entries; k > slot; k--) begin
              payloads[k] = payloads[k-1];
              ages[k]     = ages[k-1];
            end
            payloads[slot] = beat.payload;
            ages[slot]     = age;
            n_entries++;
          end
        end
        ActPeek: begin
          if (pos_ok) begin
            want.payload_out = payloads[beat.position-1];
            want.age_out     = ages[beat.position-1];
          end else begin
            want.status  = StNotFound;
            want.age_out = '1;
          end
        end
        ActRemove: begin
          if (pos_ok) begin
            want.payload_out = payloads[beat.position-1];
            for (k = beat.position; k < n_entries; k++) begin
              payloads[k-1] = payloads[k];
              ages[k-1]     = ages[k];
            end
            n_entries--;
          end else begin
            want.status  = StNotFound;
            want.age_out = '1;
          end
        end
        ActAgeAll: begin
          // saturating subtract, floors at zero
          for (k = 0; k < n_entries; k++) begin
            ages[k] = (ages[k] > beat.age_step) ? ages[k] - beat.age_step : '0;
          end
        end
        ActSetAge: begin
          if (pos_ok) begin
            ages[beat.position-1] = beat.age_value;
          end else begin
            want.status  = StNotFound;
            want.age_out = '1;
          end
        end
        default: begin
        end
      endcase
      want.count      = CntW'(n_entries);
      want.empty_flag = (n_entries == 0);
      want.full_flag  = (n_entries >= cap);
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("payload_out", want.payload_out, got.payload_out);
      compare_field("age_out", want.age_out, got.age_out);
      compare_field("count", want.count, got.count);
      compare_field("empty_flag", want.empty_flag, got.empty_flag);
      compare_field("full_flag", want.full_flag, got.full_flag);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  aorq_req_if req_if ();
  aorq_rsp_if rsp_if ();

  request_queue_checker chk = new();

  int unsigned req_idle_odds  = 0;
  int unsigned rsp_stall_odds = 0;
  bit          quiet          = 1'b0;
  int unsigned stuck_cycles   = 0;

  age_ordered_request_queue u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // note request beats and check result beats
  always @(posedge clk_i) begin : beat_monitor
    request_t req_beat;
    result_t  rsp_beat;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req_beat.action    = req_if.action;
        req_beat.payload   = req_if.payload;
        req_beat.age_value = req_if.age_value;
        req_beat.position  = req_if.position;
        req_beat.age_step  = req_if.age_step;
        chk.note_request(req_beat);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_beat.status      = status_e'(rsp_if.status);
        rsp_beat.payload_out = rsp_if.payload_out;
        rsp_beat.age_out     = rsp_if.age_out;
        rsp_beat.count       = rsp_if.count;
        rsp_beat.empty_flag  = rsp_if.empty_flag;
        rsp_beat.full_flag   = rsp_if.full_flag;
        chk.check_result(rsp_beat);
      end
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable && pwrite && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("age_ordered_request_queue_tb NOT OK");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rsp_stall_odds != 0 && $urandom_range(0, rsp_stall_odds - 1) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // one request beat, with an optional idle burst ahead of it
  task automatic send_req(logic [ActW-1:0] act, logic [PayW-1:0] pay,
                          logic [AgeW-1:0] age, logic [PosW-1:0] pos,
                          logic [AgeW-1:0] step);
    if (req_idle_odds != 0 && $urandom_range(0, req_idle_odds - 1) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.payload   <= pay;
    req_if.age_value <= age;
    req_if.position  <= pos;
    req_if.age_step  <= step;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    @(negedge clk_i);
  endtask

  // stop requests and wait for every predicted result
  task automatic settle();
    req_if.valid <= 1'b0;
    while (chk.outstanding() != 0) @(negedge clk_i);
  endtask

  // apb write of max_size, setup then access
  task automatic write_max_size(logic [CntW-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrMaxSize;
    pwdata  <= ApbDataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chk.set_max_size(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [AgeW-1:0] random_age();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom, $urandom};
      3:       return {32'd0, $urandom};
      default: return AgeW'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic pick_idling();
    if (quiet) begin
      req_idle_odds  = 0;
      rsp_stall_odds = 0;
    end else begin
      req_idle_odds  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      rsp_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
    end
  endtask

  // random request, mostly aimed at live positions
  task automatic random_request(int unsigned fill_bias);
    int unsigned     roll;
    int unsigned     cnt;
    logic [ActW-1:0] act;
    logic [PosW-1:0] pos;
    cnt  = chk.n_entries;
    roll = $urandom_range(0, 99);
    if (roll < fill_bias) begin
      act = $urandom_range(0, 1) ? ActInsert : ActAppend;
    end else if (roll < fill_bias + 25) begin
      act = ActRemove;
    end else if (roll < fill_bias + 40) begin
      act = ActPeek;
    end else if (roll < fill_bias + 50) begin
      act = ActSetAge;
    end else if (roll < 96) begin
      act = ActAgeAll;
    end else begin
      act = $urandom_range(0, 1) ? ActSpare6 : ActSpare7;
    end
    if (cnt != 0 && $urandom_range(0, 4) != 0) begin
      pos = PosW'($urandom_range(1, cnt));
    end else begin
      pos = PosW'($urandom_range(0, Depth));
    end
    send_req(act, $urandom, random_age(), pos,
             $urandom_range(0, 1) ? AgeW'($urandom_range(0, 7)) : random_age());
  endtask

  initial begin
    logic [CntW-1:0] phase_size [NumPhases];
    phase_size = '{5'd16, 5'd1, 5'd31, 5'd8, 5'd0, 5'd16, 5'd2, 5'd12, 5'd5, 5'd16};
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.action    = ActAppend;
    req_if.payload   = '0;
    req_if.age_value = '0;
    req_if.position  = '0;
    req_if.age_step  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty queue, missing positions
    req_idle_odds  = 3;
    rsp_stall_odds = 3;
    send_req(ActPeek, '0, '0, 5'd1, '0);
    send_req(ActRemove, '0, '0, 5'd0, '0);
    send_req(ActSetAge, '0, '1, 5'd16, '0);
    // sorted insert into an empty queue, then appends and ordered inserts
    send_req(ActInsert, 32'h1, '0, '0, '0);
    send_req(ActAppend, '1, '1, '0, '0);
    send_req(ActAppend, '0, '0, '0, '0);
    send_req(ActInsert, 32'hA5A5_A5A5, '1, '0, '0);
    send_req(ActInsert, 32'h5A5A_5A5A, 64'd5, '0, '0);
    send_req(ActInsert, 32'h3, '0, '0, '0);
    // peeks at and around the ends
    send_req(ActPeek, '0, '0, 5'd0, '0);
    send_req(ActPeek, '0, '0, 5'd6, '0);
    send_req(ActPeek, '0, '0, 5'd7, '0);
    send_req(ActPeek, '0, '0, 5'd16, '0);
    // set age keeps the position
    send_req(ActSetAge, '0, '1, 5'd1, '0);
    send_req(ActPeek, '0, '0, 5'd1, '0);
    send_req(ActAgeAll, '0, '0, '0, 64'd3);
    send_req(ActAgeAll, '0, '0, '0, '0);
    send_req(ActSpare6, '1, '1, 5'd1, '1);
    send_req(ActSpare7, '1, '1, 5'd1, '1);
    send_req(ActRemove, '0, '0, 5'd1, '0);
    send_req(ActRemove, '0, '0, 5'd5, '0);
    send_req(ActRemove, '0, '0, 5'd2, '0);
    send_req(ActAgeAll, '0, '0, '0, '1);
    send_req(ActPeek, '0, '0, 5'd3, '0);
    // capacity lowered below the count keeps the entries
    write_max_size(5'd2);
    send_req(ActAppend, 32'h77, '0, '0, '0);
    send_req(ActRemove, '0, '0, 5'd1, '0);
    send_req(ActInsert, 32'h78, 64'd9, '0, '0);
    // zero capacity rejects every insert
    write_max_size(5'd0);
    send_req(ActInsert, 32'h79, '0, '0, '0);
    send_req(ActRemove, '0, '0, 5'd1, '0);

    // random phases across capacity settings, fill-heavy and drain-heavy
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_max_size(phase_size[ph]);
      quiet = (ph == NumPhases - 1);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 20 == 0) pick_idling();
        random_request((ph % 2 == 0) ? 40 : 22);
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    if (chk.errors == 0) begin
      $display("age_ordered_request_queue_tb OK");
    end else begin
      $display("age_ordered_request_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> age_ordered_request_queue.f
+incdir+rtl
rtl/aorq_pkg.sv
rtl/aorq_req_if.sv
rtl/aorq_rsp_if.sv
rtl/aorq_cell.sv
rtl/age_ordered_request_queue.sv
test/age_ordered_request_queue_tb.sv
